// ----- rtl/core/rqps_pkg.sv -----
package rqps_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] FN_ENQ   = 2'd0;
    localparam logic [1:0] FN_FRONT = 2'd1;
    localparam logic [1:0] FN_POP   = 2'd2;
    localparam logic [1:0] FN_AGE   = 2'd3;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_SJF   = 2'd1;
    localparam logic [1:0] POL_AGING = 2'd2;

    typedef logic [2:0] t_addr_sel;
    localparam t_addr_sel AS_IDX     = 3'd0;
    localparam t_addr_sel AS_IDX_M1  = 3'd1;
    localparam t_addr_sel AS_TAIL    = 3'd2;
    localparam t_addr_sel AS_HEAD    = 3'd3;
    localparam t_addr_sel AS_HEAD_M1 = 3'd4;

    typedef logic [1:0] t_wd_sel;
    localparam t_wd_sel WD_ITEM = 2'd0;
    localparam t_wd_sel WD_COPY = 2'd1;
    localparam t_wd_sel WD_AGED = 2'd2;

    typedef logic [2:0] t_idx_op;
    localparam t_idx_op IX_HOLD  = 3'd0;
    localparam t_idx_op IX_ZERO  = 3'd1;
    localparam t_idx_op IX_COUNT = 3'd2;
    localparam t_idx_op IX_INC   = 3'd3;
    localparam t_idx_op IX_DEC   = 3'd4;

    typedef logic [1:0] t_ptr_op;
    localparam t_ptr_op PO_HOLD = 2'd0;
    localparam t_ptr_op PO_INC  = 2'd1;
    localparam t_ptr_op PO_DEC  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  pid;
        logic [15:0] code_length;
        logic [15:0] score;
        logic        tie_front;
    } t_req;

    typedef struct packed {
        logic        deq_valid;
        logic [7:0]  deq_pid;
        logic [15:0] deq_code_length;
        logic [15:0] deq_score;
        logic        queue_empty;
        logic [4:0]  occupancy;
        logic        overflow;
    } t_rsp;

    typedef struct packed {
        logic      latch;
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        t_idx_op   idx_op;
        logic      pos_load;
        t_ptr_op   head_op;
        t_ptr_op   cnt_op;
        logic      res_pop;
        logic      res_ovf;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] policy;
        logic       full;
        logic       empty;
        logic       idx_lt_cnt;
        logic       idx_gt_pos;
        logic       scan_go;
        logic       out_free;
    } t_sts;

endpackage

// ----- rtl/core/rqps_if.sv -----
interface rqps_req_if;
    import rqps_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rqps_rsp_if;
    import rqps_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/rqps_ctrl.sv -----
module rqps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  rqps_pkg::t_sts  i_sts,
    output rqps_pkg::t_cmd  o_cmd
);
    import rqps_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_SH_RD    = 4'd4;
    localparam logic [3:0] S_SH_WR    = 4'd5;
    localparam logic [3:0] S_POP      = 4'd6;
    localparam logic [3:0] S_AGE_RD   = 4'd7;
    localparam logic [3:0] S_AGE_WR   = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = AS_IDX;
        o_cmd.wd_sel   = WD_ITEM;
        o_cmd.idx_op   = IX_HOLD;
        o_cmd.head_op  = PO_HOLD;
        o_cmd.cnt_op   = PO_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.func inside {FN_ENQ, FN_FRONT}) begin
                    if (i_sts.full) begin
                        o_cmd.res_ovf = 1'b1;
                        n_state       = S_FIN;
                    end else if (i_sts.func == FN_FRONT) begin
                        o_cmd.mem_wr   = 1'b1;
                        o_cmd.addr_sel = AS_HEAD_M1;
                        o_cmd.head_op  = PO_DEC;
                        o_cmd.cnt_op   = PO_INC;
                        n_state        = S_FIN;
                    end else if (i_sts.policy inside {POL_SJF, POL_AGING}) begin
                        o_cmd.idx_op = IX_ZERO;
                        n_state      = S_SCAN_RD;
                    end else begin
                        o_cmd.mem_wr   = 1'b1;
                        o_cmd.addr_sel = AS_TAIL;
                        o_cmd.cnt_op   = PO_INC;
                        n_state        = S_FIN;
                    end
                end else if (i_sts.func == FN_POP) begin
                    if (i_sts.empty) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.mem_rd   = 1'b1;
                        o_cmd.addr_sel = AS_HEAD;
                        n_state        = S_POP;
                    end
                end else begin
                    o_cmd.idx_op = IX_ZERO;
                    n_state      = S_AGE_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_SCAN_CHK;
                end else begin
                    o_cmd.pos_load = 1'b1;
                    o_cmd.idx_op   = IX_COUNT;
                    n_state        = S_SH_RD;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.scan_go) begin
                    o_cmd.idx_op = IX_INC;
                    n_state      = S_SCAN_RD;
                end else begin
                    o_cmd.pos_load = 1'b1;
                    o_cmd.idx_op   = IX_COUNT;
                    n_state        = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.idx_gt_pos) begin
                    o_cmd.mem_rd   = 1'b1;
                    o_cmd.addr_sel = AS_IDX_M1;
                    n_state        = S_SH_WR;
                end else begin
                    o_cmd.mem_wr = 1'b1;
                    o_cmd.cnt_op = PO_INC;
                    n_state      = S_FIN;
                end
            end
            S_SH_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.wd_sel = WD_COPY;
                o_cmd.idx_op = IX_DEC;
                n_state      = S_SH_RD;
            end
            S_POP: begin
                o_cmd.res_pop = 1'b1;
                o_cmd.head_op = PO_INC;
                o_cmd.cnt_op  = PO_DEC;
                n_state       = S_FIN;
            end
            S_AGE_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_AGE_WR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_AGE_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.wd_sel = WD_AGED;
                o_cmd.idx_op = IX_INC;
                n_state      = S_AGE_RD;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/rqps_dp.sv -----
module rqps_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_wdata,
    input  rqps_pkg::t_req  i_req_data,
    input  rqps_pkg::t_cmd  i_cmd,
    output rqps_pkg::t_sts  o_sts,
    output logic            o_rsp_valid,
    output rqps_pkg::t_rsp  o_rsp_data,
    input  logic            i_rsp_ready
);
    import rqps_pkg::*;

    localparam int SW = CW + 1;

    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] len;
        logic [15:0] score;
    } t_entry;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_entry          r_mem [DEPTH];
    t_entry          r_rd_data;
    t_req            r_item;
    logic [1:0]      r_policy;
    logic [AW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_pos;
    logic            r_res_dv;
    t_entry          r_res_ent;
    logic            r_res_ovf;
    logic            r_out_valid;
    t_rsp            r_out;

    logic [AW-1:0]   w_addr;
    logic [AW-1:0]   w_head_m1;
    t_entry          w_wdata;
    logic            w_scan_go;

    assign w_head_m1 = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;

    always_comb begin
        case (i_cmd.addr_sel)
            AS_IDX:     w_addr = f_wrap(r_head, r_idx);
            AS_IDX_M1:  w_addr = f_wrap(r_head, r_idx - 1'b1);
            AS_TAIL:    w_addr = f_wrap(r_head, r_count);
            AS_HEAD:    w_addr = r_head;
            AS_HEAD_M1: w_addr = w_head_m1;
            default:    w_addr = r_head;
        endcase
    end

    always_comb begin
        case (i_cmd.wd_sel)
            WD_ITEM: w_wdata = {r_item.pid, r_item.code_length, r_item.score};
            WD_COPY: w_wdata = r_rd_data;
            WD_AGED: begin
                w_wdata = r_rd_data;
                if (r_rd_data.score != '0) begin
                    w_wdata.score = r_rd_data.score - 1'b1;
                end
            end
            default: w_wdata = {r_item.pid, r_item.code_length, r_item.score};
        endcase
    end

    always_comb begin
        case (r_policy)
            POL_SJF:   w_scan_go = (r_rd_data.len <= r_item.code_length);
            POL_AGING: w_scan_go = r_item.tie_front ? (r_rd_data.score < r_item.score)
                                                    : (r_rd_data.score <= r_item.score);
            default:   w_scan_go = 1'b0;
        endcase
    end

    assign o_sts.func       = r_item.func;
    assign o_sts.policy     = r_policy;
    assign o_sts.full       = (r_count == CW'(DEPTH));
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.idx_lt_cnt = (r_idx < r_count);
    assign o_sts.idx_gt_pos = (r_idx > r_pos);
    assign o_sts.scan_go    = w_scan_go;
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_req_data;
        end
        case (i_cmd.idx_op)
            IX_ZERO:  r_idx <= '0;
            IX_COUNT: r_idx <= r_count;
            IX_INC:   r_idx <= r_idx + 1'b1;
            IX_DEC:   r_idx <= r_idx - 1'b1;
            default:  r_idx <= r_idx;
        endcase
        if (i_cmd.pos_load) begin
            r_pos <= r_idx;
        end
        if (i_cmd.latch) begin
            r_res_dv  <= 1'b0;
            r_res_ent <= '0;
            r_res_ovf <= 1'b0;
        end else begin
            if (i_cmd.res_pop) begin
                r_res_dv  <= 1'b1;
                r_res_ent <= r_rd_data;
            end
            if (i_cmd.res_ovf) begin
                r_res_ovf <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_out.deq_valid       <= r_res_dv;
            r_out.deq_pid         <= r_res_ent.pid;
            r_out.deq_code_length <= r_res_ent.len;
            r_out.deq_score       <= r_res_ent.score;
            r_out.queue_empty     <= (r_count == '0);
            r_out.occupancy       <= 5'(r_count);
            r_out.overflow        <= r_res_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FIFO;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            case (i_cmd.head_op)
                PO_INC:  r_head <= f_wrap(r_head, CW'(1));
                PO_DEC:  r_head <= w_head_m1;
                default: r_head <= r_head;
            endcase
            case (i_cmd.cnt_op)
                PO_INC:  r_count <= r_count + 1'b1;
                PO_DEC:  r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

endmodule

// ----- rtl/core/ready_queue_priority_scheduler_top.sv -----
// Ordered ready queue of up to sixteen process entries, held in a circular single-port
// memory with a head pointer, so that a pop or a front insert costs no shifting. One request
// is handled at a time. A tail append, a front insert or a dropped enqueue is done in the
// dispatch state, and a pop reads the head entry there and takes it in the pop state. An
// age pass makes one read and one write of the memory port per held entry. A sorted enqueue
// first scans for the insert position p, reading the held entries one at a time, then the
// entries behind p are moved back one at a time through the same port.
// The next request is accepted while the previous result still waits in the output register;
// a new result that finds that register still full waits for it to be taken.
module ready_queue_priority_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    rqps_req_if.sink    i_req,
    rqps_rsp_if.source  o_rsp
);
    import rqps_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_req_ready;

    assign i_req.ready = w_req_ready;

    rqps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rqps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_data  (i_req.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data),
        .i_rsp_ready (o_rsp.ready)
    );

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.occupancy <= 5'(DEPTH)))
        else $error("occupancy above queue depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.overflow) |->
            (o_rsp.data.occupancy == 5'(DEPTH)) && !o_rsp.data.deq_valid)
        else $error("overflow reported on a queue that is not full");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.data.queue_empty == (o_rsp.data.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_no_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.deq_valid) |->
            (o_rsp.data.deq_pid == '0) && (o_rsp.data.deq_code_length == '0) &&
            (o_rsp.data.deq_score == '0))
        else $error("popped entry fields set without a pop");

endmodule
